### sv/bdu_pkg.sv
// ----------------------------------------------------------------------------
// bdu_pkg
// Shared types and constants of the byte order mark detecting UTF-16LE to
// UTF-8 line transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bdu_pkg;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Result kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Byte and code unit constants
  localparam logic [7:0]  CR8    = 8'h0D;
  localparam logic [7:0]  LF8    = 8'h0A;
  localparam logic [15:0] CR16   = 16'h000D;
  localparam logic [15:0] LF16   = 16'h000A;
  localparam logic [15:0] LIM1   = 16'h0080;
  localparam logic [15:0] LIM2   = 16'h0800;
  localparam logic [7:0]  BOM_FF = 8'hFF;
  localparam logic [7:0]  BOM_FE = 8'hFE;
  localparam logic [7:0]  BOM_EF = 8'hEF;
  localparam logic [7:0]  BOM_BB = 8'hBB;
  localparam logic [7:0]  BOM_BF = 8'hBF;

  // At most three results come from one item
  localparam int MAX_RES = 3;

  // Default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Mark detection stage, one-hot
  typedef enum logic [4:0] {
    DET_FIRST = 5'b00001,
    DET_FF    = 5'b00010,
    DET_EF    = 5'b00100,
    DET_EFBB  = 5'b01000,
    DET_DONE  = 5'b10000
  } det_stage_t;

  // One result
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } slot_t;

  // All results of one item
  typedef struct packed {
    logic [1:0]          cnt;
    slot_t [MAX_RES-1:0] slot;
  } job_t;

  // Classify a byte read as UTF-8 text: CR or LF ends the line
  function automatic slot_t text8(input logic [7:0] b);
    slot_t s;
    s.kind = (b == CR8) || (b == LF8);
    s.data = s.kind ? 8'h00 : b;
    return s;
  endfunction

  // Line end result
  function automatic slot_t eol_slot();
    slot_t s;
    s.kind = KIND_EOL;
    s.data = 8'h00;
    return s;
  endfunction

  // Plain text byte result
  function automatic slot_t txt_slot(input logic [7:0] b);
    slot_t s;
    s.kind = KIND_TEXT;
    s.data = b;
    return s;
  endfunction

endpackage

`default_nettype wire

### sv/bdu_if.sv
// ----------------------------------------------------------------------------
// bdu_in_if / bdu_out_if
// Valid/ready channels for raw stream bytes and for transcoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdu_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface bdu_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

### sv/bdu_front.sv
// ----------------------------------------------------------------------------
// bdu_front
// Accepts stream items, tracks mark detection and line state, and turns each
// item into a job of zero to three results for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bdu_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_operation,
  input  wire logic [7:0]   in_data_byte,
  output logic              job_valid,
  input  wire logic         job_ready,
  output bdu_pkg::job_t     job
);
  import bdu_pkg::*;

  det_stage_t  stage_r, stage_nxt;
  logic        utf16_r, utf16_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        have_low_r, have_low_nxt;
  logic        cr_pend_r, cr_pend_nxt;
  logic        line_open_r, line_open_nxt;

  logic        accept;
  logic [1:0]  n;
  logic [15:0] u;
  logic [7:0]  b;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_data_byte;
  assign u        = {in_data_byte, low_r};

  // Classify the item and build its job
  always_comb begin
    stage_nxt     = stage_r;
    utf16_nxt     = utf16_r;
    low_nxt       = low_r;
    have_low_nxt  = have_low_r;
    cr_pend_nxt   = cr_pend_r;
    line_open_nxt = line_open_r;
    job           = '0;
    n             = 2'd0;

    if (accept) begin
      if (in_operation == OP_EOS) begin
        // replay held mark bytes, then close an open line
        priority if (stage_r == DET_FF) begin
          job.slot[n] = text8(BOM_FF);
          line_open_nxt = 1'b1;
          n = n + 2'd1;
        end else if (stage_r == DET_EF) begin
          job.slot[n] = text8(BOM_EF);
          line_open_nxt = 1'b1;
          n = n + 2'd1;
        end else if (stage_r == DET_EFBB) begin
          job.slot[n] = text8(BOM_EF);
          n = n + 2'd1;
          job.slot[n] = text8(BOM_BB);
          line_open_nxt = 1'b1;
          n = n + 2'd1;
        end else begin
          // no mark bytes held
        end
        if (line_open_nxt) begin
          job.slot[n] = eol_slot();
          n = n + 2'd1;
        end
        stage_nxt     = DET_FIRST;
        utf16_nxt     = 1'b0;
        have_low_nxt  = 1'b0;
        cr_pend_nxt   = 1'b0;
        line_open_nxt = 1'b0;
      end else begin
        unique case (stage_r)
          DET_FIRST: begin
            priority if (b == BOM_FF) begin
              stage_nxt = DET_FF;
            end else if (b == BOM_EF) begin
              stage_nxt = DET_EF;
            end else begin
              stage_nxt = DET_DONE;
              job.slot[n] = text8(b);
              line_open_nxt = !job.slot[n].kind;
              n = n + 2'd1;
            end
          end
          DET_FF: begin
            stage_nxt = DET_DONE;
            if (b == BOM_FE) begin
              utf16_nxt = 1'b1;
            end else begin
              job.slot[n] = text8(BOM_FF);
              n = n + 2'd1;
              job.slot[n] = text8(b);
              line_open_nxt = !job.slot[n].kind;
              n = n + 2'd1;
            end
          end
          DET_EF: begin
            if (b == BOM_BB) begin
              stage_nxt = DET_EFBB;
            end else begin
              stage_nxt = DET_DONE;
              job.slot[n] = text8(BOM_EF);
              n = n + 2'd1;
              job.slot[n] = text8(b);
              line_open_nxt = !job.slot[n].kind;
              n = n + 2'd1;
            end
          end
          DET_EFBB: begin
            stage_nxt = DET_DONE;
            if (b != BOM_BF) begin
              job.slot[n] = text8(BOM_EF);
              n = n + 2'd1;
              job.slot[n] = text8(BOM_BB);
              n = n + 2'd1;
              job.slot[n] = text8(b);
              line_open_nxt = !job.slot[n].kind;
              n = n + 2'd1;
            end
          end
          // mode decided
          default: begin
            if (!utf16_r) begin
              job.slot[n] = text8(b);
              line_open_nxt = !job.slot[n].kind;
              n = n + 2'd1;
            end else if (!have_low_r) begin
              low_nxt      = b;
              have_low_nxt = 1'b1;
            end else begin
              have_low_nxt = 1'b0;
              cr_pend_nxt  = 1'b0;
              // drop LF right after CR
              if (!(cr_pend_r && u == LF16)) begin
                priority if (u == CR16) begin
                  cr_pend_nxt   = 1'b1;
                  line_open_nxt = 1'b0;
                  job.slot[n]   = eol_slot();
                  n = n + 2'd1;
                end else if (u == LF16) begin
                  line_open_nxt = 1'b0;
                  job.slot[n]   = eol_slot();
                  n = n + 2'd1;
                end else if (u < LIM1) begin
                  line_open_nxt = 1'b1;
                  job.slot[n]   = txt_slot(u[7:0]);
                  n = n + 2'd1;
                end else if (u < LIM2) begin
                  line_open_nxt = 1'b1;
                  job.slot[n]   = txt_slot({3'b110, u[10:6]});
                  n = n + 2'd1;
                  job.slot[n]   = txt_slot({2'b10, u[5:0]});
                  n = n + 2'd1;
                end else begin
                  line_open_nxt = 1'b1;
                  job.slot[n]   = txt_slot({4'b1110, u[15:12]});
                  n = n + 2'd1;
                  job.slot[n]   = txt_slot({2'b10, u[11:6]});
                  n = n + 2'd1;
                  job.slot[n]   = txt_slot({2'b10, u[5:0]});
                  n = n + 2'd1;
                end
              end
            end
          end
        endcase
      end
    end
    job.cnt   = n;
    job_valid = accept && (n != 2'd0);
  end

  // Hold detection and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= DET_FIRST;
      utf16_r     <= 1'b0;
      have_low_r  <= 1'b0;
      cr_pend_r   <= 1'b0;
      line_open_r <= 1'b0;
    end else begin
      stage_r     <= stage_nxt;
      utf16_r     <= utf16_nxt;
      have_low_r  <= have_low_nxt;
      cr_pend_r   <= cr_pend_nxt;
      line_open_r <= line_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r <= low_nxt;
  end

endmodule

`default_nettype wire

### sv/bdu_queue.sv
// ----------------------------------------------------------------------------
// bdu_queue
// Small job queue between front and back; each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bdu_queue #(
  parameter int Depth = bdu_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire bdu_pkg::job_t push_job,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output bdu_pkg::job_t      pop_job
);
  import bdu_pkg::*;

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(Depth - 1);

  job_t          mem_r [Depth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### sv/bdu_back.sv
// ----------------------------------------------------------------------------
// bdu_back
// Walks the head job slot by slot into the registered result output, one
// result per cycle unless stalled, and pops the job with its last result.
// ----------------------------------------------------------------------------
`default_nettype none

module bdu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_pop,
  input  wire bdu_pkg::job_t job,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_kind,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import bdu_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  slot_t      slot_r, slot_nxt;
  logic       last_r, last_nxt;
  logic       load, is_last;

  assign load    = job_valid && (!valid_r || out_ready);
  assign is_last = (idx_r == job.cnt - 2'd1);
  assign job_pop = load && is_last;

  // Load the next slot when the output register frees up
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      slot_nxt  = job.slot[idx_r];
      last_nxt  = is_last;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_kind  = slot_r.kind;
  assign out_byte  = slot_r.data;
  assign out_last  = last_r;

endmodule

`default_nettype wire

### sv/bom_detect_utf16le_to_utf8_lines.sv
// Path: jobs are registered in the job queue, results in the output register.
// Throughput: one input item per cycle while the job queue has room; the back
// end emits one result per cycle while the receiver is ready.
// Reset: synchronous active-low rst_n clears detection state, queue and output.
// ----------------------------------------------------------------------------
// bom_detect_utf16le_to_utf8_lines
// Detects a byte order mark, then transcodes UTF-16LE or passes UTF-8 text,
// emitting text bytes and line-end marks.
// ----------------------------------------------------------------------------
`default_nettype none

module bom_detect_utf16le_to_utf8_lines #(
  parameter int QueueDepth = bdu_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bdu_in_if.sink     in_chan,
  bdu_out_if.source  out_chan
);
  import bdu_pkg::*;

  logic front_valid, front_ready;
  job_t front_job;
  logic head_valid, head_pop;
  job_t head_job;

  // Classify items
  bdu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_operation (in_chan.operation),
    .in_data_byte (in_chan.data_byte),
    .job_valid    (front_valid),
    .job_ready    (front_ready),
    .job          (front_job)
  );

  // Decouple front and back
  bdu_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_job    (head_job)
  );

  // Serialize results
  bdu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job_pop   (head_pop),
    .job       (head_job),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_kind  (out_chan.kind),
    .out_byte  (out_chan.out_byte),
    .out_last  (out_chan.last_of_run)
  );

endmodule

`default_nettype wire

### sv/bdu_checker.sv
// ----------------------------------------------------------------------------
// bdu_checker
// Port-level checks of the transcoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bdu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);
  import bdu_pkg::*;

  // A line-end item carries a zero byte
  a_eol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EOL) |-> out_byte == 8'h00)
    else $error("line end with nonzero byte");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

  // Valid is always known, and a valid result carries known fields
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_valid)
      && (!out_valid || !$isunknown({out_kind, out_byte, out_last})))
    else $error("unknown value on result channel");

endmodule

bind bom_detect_utf16le_to_utf8_lines bdu_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.kind),
  .out_byte  (out_chan.out_byte),
  .out_last  (out_chan.last_of_run)
);

`default_nettype wire

### tb/sv/bom_detect_utf16le_to_utf8_lines_tb.sv
// ----------------------------------------------------------------------------
// bom_detect_utf16le_to_utf8_lines_tb
// Self-checking bench for the byte order mark detecting line transcoder.
// Feeds byte streams with and without marks, in both text modes, with broken
// marks and early stream ends. A local transcoder computes the expected text
// bytes and line ends for each item, and every result is checked in order.
// Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module bom_detect_utf16le_to_utf8_lines_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdu_pkg::*;

  // UTF-8 lead and continuation patterns
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] CONT  = 8'h80;

  // Receiver stall modes
  localparam int STALL_NONE    = 0;
  localparam int STALL_PATTERN = 1;
  localparam int STALL_RANDOM  = 2;

  localparam int RANDOM_ITEMS = 220;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  logic clk;
  logic rst_n;

  bdu_in_if  in_chan ();
  bdu_out_if out_chan ();

  bom_detect_utf16le_to_utf8_lines u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Results still owed by the block, oldest first
  result_t due_results[$];
  int      errors = 0;
  int      items_sent = 0;
  int      burst_left = 0;

  // Local copy of the transcoder state
  det_stage_t mark_stage;
  logic       utf16_sel;
  logic [7:0] held_low;
  logic       low_held;
  logic       cr_seen;
  logic       text_on_line;

  // Receiver stall state
  int         stall_mode = STALL_NONE;
  int         mode_cycles = 0;
  logic [7:0] stall_pat = 8'hB6;

  // Clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Expected-result transcoder
  // --------------------------------------------------------------------------
  function automatic void clear_scan();
    mark_stage   = DET_FIRST;
    utf16_sel    = 1'b0;
    held_low     = 8'h00;
    low_held     = 1'b0;
    cr_seen      = 1'b0;
    text_on_line = 1'b0;
  endfunction

  function automatic void owe_result(input logic kind, input logic [7:0] b);
    result_t r;
    r.kind = kind;
    r.data = (kind == KIND_EOL) ? 8'h00 : b;
    r.last = 1'b0;
    due_results = {due_results, r};
  endfunction

  // Byte read as UTF-8 text: CR or LF closes the line
  function automatic void owe_text8(input logic [7:0] b);
    if (b == CR8 || b == LF8) begin
      text_on_line = 1'b0;
      owe_result(KIND_EOL, 8'h00);
    end else begin
      text_on_line = 1'b1;
      owe_result(KIND_TEXT, b);
    end
  endfunction

  // One UTF-16 code unit, encoded on its own
  function automatic void owe_unit16(input logic [15:0] u);
    if (cr_seen) begin
      cr_seen = 1'b0;
      // drop LF right after CR
      if (u == LF16) return;
    end
    if (u == CR16) begin
      cr_seen      = 1'b1;
      text_on_line = 1'b0;
      owe_result(KIND_EOL, 8'h00);
    end else if (u == LF16) begin
      text_on_line = 1'b0;
      owe_result(KIND_EOL, 8'h00);
    end else begin
      text_on_line = 1'b1;
      if (u < LIM1) begin
        owe_result(KIND_TEXT, u[7:0]);
      end else if (u < LIM2) begin
        owe_result(KIND_TEXT, LEAD2 | {3'b000, u[10:6]});
        owe_result(KIND_TEXT, CONT | {2'b00, u[5:0]});
      end else begin
        owe_result(KIND_TEXT, LEAD3 | {4'h0, u[15:12]});
        owe_result(KIND_TEXT, CONT | {2'b00, u[11:6]});
        owe_result(KIND_TEXT, CONT | {2'b00, u[5:0]});
      end
    end
  endfunction

  function automatic void transcode_item(input logic op, input logic [7:0] b);
    int first;
    first = due_results.size();
    if (op == OP_EOS) begin
      // replay held mark bytes, close an open line, restart
      case (mark_stage)
        DET_FF:   owe_text8(BOM_FF);
        DET_EF:   owe_text8(BOM_EF);
        DET_EFBB: begin
          owe_text8(BOM_EF);
          owe_text8(BOM_BB);
        end
        default: ;
      endcase
      if (text_on_line) owe_result(KIND_EOL, 8'h00);
      clear_scan();
    end else begin
      case (mark_stage)
        DET_FIRST: begin
          if (b == BOM_FF) begin
            mark_stage = DET_FF;
          end else if (b == BOM_EF) begin
            mark_stage = DET_EF;
          end else begin
            mark_stage = DET_DONE;
            owe_text8(b);
          end
        end
        DET_FF: begin
          mark_stage = DET_DONE;
          if (b == BOM_FE) begin
            utf16_sel = 1'b1;
          end else begin
            owe_text8(BOM_FF);
            owe_text8(b);
          end
        end
        DET_EF: begin
          if (b == BOM_BB) begin
            mark_stage = DET_EFBB;
          end else begin
            mark_stage = DET_DONE;
            owe_text8(BOM_EF);
            owe_text8(b);
          end
        end
        DET_EFBB: begin
          mark_stage = DET_DONE;
          if (b != BOM_BF) begin
            owe_text8(BOM_EF);
            owe_text8(BOM_BB);
            owe_text8(b);
          end
        end
        default: begin
          if (!utf16_sel) begin
            owe_text8(b);
          end else if (low_held) begin
            low_held = 1'b0;
            owe_unit16({b, held_low});
          end else begin
            held_low = b;
            low_held = 1'b1;
          end
        end
      endcase
    end
    // mark the final result of this item
    if (due_results.size() > first) due_results[due_results.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_chan.valid     <= 1'b0;
    in_chan.operation <= 1'($urandom);
    in_chan.data_byte <= 8'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Send one item, hold it until taken, then predict its results
  task automatic send_item(input logic op, input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.data_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    transcode_item(op, b);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  task automatic send_eos();
    send_item(OP_EOS, 8'($urandom));
  endtask

  task automatic send_unit(input logic [15:0] u);
    send_byte(u[7:0]);
    send_byte(u[15:8]);
  endtask

  // --------------------------------------------------------------------------
  // Receiver stalls and result checks
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  = $urandom_range(STALL_NONE, STALL_RANDOM);
      mode_cycles = $urandom_range(20, 80);
      stall_pat   = 8'($urandom) | 8'h01;
    end
    mode_cycles--;
    case (stall_mode)
      STALL_NONE: out_chan.ready <= 1'b1;
      STALL_PATTERN: begin
        out_chan.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      default: out_chan.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0d", $time,
                 out_chan.kind, out_chan.out_byte, out_chan.last_of_run);
      end else begin
        want = due_results.pop_front();
        if (out_chan.kind !== want.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_chan.kind);
        end
        if (out_chan.out_byte !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data,
                   out_chan.out_byte);
        end
        if (out_chan.last_of_run !== want.last) begin
          errors++;
          $display("%0t: last_of_run expected %0d actual %0d", $time, want.last,
                   out_chan.last_of_run);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // UTF-16LE mark, units 0041 and FFFF, CR LF folding, lone LF, odd byte at end
  task automatic test_bom_utf16();
    send_byte(BOM_FF);
    send_byte(BOM_FE);
    send_unit(16'h0041);
    send_unit(16'hFFFF);
    send_unit(CR16);
    send_unit(LF16);
    send_unit(LF16);
    send_byte(8'h7F);
    send_eos();
  endtask

  // UTF-8 mark, CRLF as two line ends, top byte value, line closed at end
  task automatic test_bom_utf8();
    send_byte(BOM_EF);
    send_byte(BOM_BB);
    send_byte(BOM_BF);
    send_byte(CR8);
    send_byte(LF8);
    send_byte(8'hFF);
    send_eos();
  endtask

  // Mark broken after two bytes, and a stream that ends inside a mark
  task automatic test_broken_marks();
    send_byte(BOM_EF);
    send_byte(BOM_BB);
    send_byte(8'h00);
    send_eos();
    send_byte(BOM_FF);
    send_eos();
  endtask

  function automatic logic [15:0] pick_unit();
    logic [15:0] u;
    case ($urandom_range(0, 9))
      0:       u = CR16;
      1:       u = LF16;
      2, 3:    u = 16'($urandom_range(0, 16'h007F));
      4:       u = 16'($urandom_range(16'h0080, 16'h07FF));
      5:       u = 16'($urandom_range(16'h0800, 16'hFFFF));
      6:       u = 16'hD800 + 16'($urandom_range(0, 16'h07FF));
      7: begin
        case ($urandom_range(0, 5))
          0:       u = 16'h0000;
          1:       u = 16'h007F;
          2:       u = 16'h0080;
          3:       u = 16'h07FF;
          4:       u = 16'h0800;
          default: u = 16'hFFFF;
        endcase
      end
      default: u = 16'($urandom);
    endcase
    return u;
  endfunction

  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(0, 4) == 0) return ($urandom_range(0, 1) != 0) ? CR8 : LF8;
    return 8'($urandom);
  endfunction

  // Whole streams of every shape, each closed by an end of stream
  task automatic test_random_streams();
    int start;
    int count;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      count = $urandom_range(1, 10);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_byte(BOM_FF);
          send_byte(BOM_FE);
          repeat (count) send_unit(pick_unit());
          if ($urandom_range(0, 3) == 0) send_byte(8'($urandom));
        end
        5, 6: begin
          send_byte(BOM_EF);
          send_byte(BOM_BB);
          send_byte(BOM_BF);
          repeat (count) send_byte(pick_text_byte());
        end
        7: begin
          repeat (count) send_byte(pick_text_byte());
        end
        8: begin
          // broken or cut-off mark
          case ($urandom_range(0, 2))
            0: send_byte(BOM_FF);
            1: send_byte(BOM_EF);
            default: begin
              send_byte(BOM_EF);
              send_byte(BOM_BB);
            end
          endcase
          if ($urandom_range(0, 1) != 0) repeat (count) send_byte(pick_text_byte());
        end
        default: begin
          // noise with stray stream ends
          repeat (count) begin
            if ($urandom_range(0, 3) == 0) send_eos();
            else send_byte(8'($urandom));
          end
        end
      endcase
      send_eos();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.operation  = OP_BYTE;
    in_chan.data_byte  = 8'h00;
    out_chan.ready     = 1'b0;
    clear_scan();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_bom_utf16();
    test_bom_utf8();
    test_broken_marks();
    test_random_streams();

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/bdu_pkg.sv
sv/bdu_if.sv
sv/bdu_front.sv
sv/bdu_queue.sv
sv/bdu_back.sv
sv/bom_detect_utf16le_to_utf8_lines.sv
sv/bdu_checker.sv
tb/sv/bom_detect_utf16le_to_utf8_lines_tb.sv
